// ===== rtl/pse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = Q_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [2:0] {
        K_OPERAND = 3'd0,
        K_ADD     = 3'd1,
        K_SUB     = 3'd2,
        K_MUL     = 3'd3,
        K_DIV     = 3'd4,
        K_FINISH  = 3'd5,
        K_INVALID = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FEW      = 3'd1,
        ST_COUNT    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_INVALID  = 3'd4,
        ST_DIVZERO  = 3'd5,
        ST_SAT      = 3'd6
    } t_status;

    typedef struct packed {
        t_kind                  kind;
        logic signed [Q_W-1:0]  operand_value;
    } t_in_item;

    typedef struct packed {
        logic signed [Q_W-1:0]  result_value;
        t_status                status;
    } t_out_item;

    typedef struct packed {
        logic  start;
        t_kind op;
    } t_alu_cmd;

    typedef struct packed {
        logic           done;
        logic           sat;
        logic [Q_W-1:0] value;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT
    } t_ctl_state;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MULR,
        A_DIV,
        A_DFIN,
        A_DONE
    } t_alu_state;

endpackage

`default_nettype wire

// ===== rtl/pse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/pse_alu.sv =====
// Q16.16 arithmetic unit: add/sub, registered multiply, radix-2 iterative divide.
`timescale 1ns / 1ps
`default_nettype none

module pse_alu (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire pse_pkg::t_alu_cmd        i_cmd,
    input  wire logic [pse_pkg::Q_W-1:0]  i_a,
    input  wire logic [pse_pkg::Q_W-1:0]  i_b,
    output pse_pkg::t_alu_rsp             o_rsp
);

    localparam int QW  = pse_pkg::Q_W;
    localparam int FW  = pse_pkg::FRAC_W;
    localparam int P_W = 2 * QW;
    localparam int N_W = QW + FW;

    pse_pkg::t_alu_state r_state, n_state;

    logic [QW:0]             w_sum;
    logic                    w_sum_sat;
    logic signed [P_W-1:0]   r_prod;
    logic signed [P_W-1:0]   w_rnd;
    logic signed [P_W-1:0]   w_shr;
    logic                    w_mul_sat;
    logic [QW-1:0]           w_a_mag;
    logic [QW-1:0]           w_b_mag;
    logic [N_W-1:0]          w_num;
    logic                    w_big;
    logic [QW-1:0]           r_rem;
    logic [QW-1:0]           r_quo;
    logic [QW-1:0]           r_div;
    logic                    r_neg;
    logic                    r_big;
    logic [pse_pkg::STEP_W-1:0] r_step;
    logic [QW:0]             w_trial;
    logic [QW:0]             w_diff;
    logic                    w_ge;
    logic [QW-1:0]           w_dfin_val;
    logic                    w_dfin_sat;
    logic [QW-1:0]           r_val;
    logic                    r_sat;

    // add / subtract with saturation
    always_comb begin
        if (i_cmd.op == pse_pkg::K_SUB) begin
            w_sum = {i_a[QW-1], i_a} - {i_b[QW-1], i_b};
        end else begin
            w_sum = {i_a[QW-1], i_a} + {i_b[QW-1], i_b};
        end
        w_sum_sat = w_sum[QW] ^ w_sum[QW-1];
    end

    // multiply: round to nearest, floor shift, saturate
    always_comb begin
        w_rnd     = r_prod + P_W'(64'sd1 <<< (FW - 1));
        w_shr     = w_rnd >>> FW;
        w_mul_sat = !((&w_shr[P_W-1:QW-1]) || (~|w_shr[P_W-1:QW-1]));
    end

    // divide setup: magnitudes and early overflow check
    always_comb begin
        w_a_mag = i_a[QW-1] ? (~i_a + 1'b1) : i_a;
        w_b_mag = i_b[QW-1] ? (~i_b + 1'b1) : i_b;
        w_num   = {w_a_mag, {FW{1'b0}}};
        w_big   = {{(QW-FW){1'b0}}, w_num[N_W-1:QW]} >= w_b_mag;
    end

    // one restoring step per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[QW-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = w_trial >= {1'b0, r_div};
    end

    always_comb begin
        w_dfin_sat = 1'b0;
        if (r_neg) begin
            if (r_big || (r_quo > pse_pkg::Q_MIN)) begin
                w_dfin_sat = 1'b1;
                w_dfin_val = pse_pkg::Q_MIN;
            end else begin
                w_dfin_val = ~r_quo + 1'b1;
            end
        end else begin
            if (r_big || r_quo[QW-1]) begin
                w_dfin_sat = 1'b1;
                w_dfin_val = pse_pkg::Q_MAX;
            end else begin
                w_dfin_val = r_quo;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pse_pkg::A_IDLE: begin
                if (i_cmd.start) begin
                    unique case (i_cmd.op) inside
                        pse_pkg::K_MUL: n_state = pse_pkg::A_MULR;
                        pse_pkg::K_DIV: n_state = pse_pkg::A_DIV;
                        default:        n_state = pse_pkg::A_DONE;
                    endcase
                end
            end
            pse_pkg::A_MULR: n_state = pse_pkg::A_DONE;
            pse_pkg::A_DIV: begin
                if (r_step == pse_pkg::STEP_W'(pse_pkg::DIV_STEPS - 1)) begin
                    n_state = pse_pkg::A_DFIN;
                end
            end
            pse_pkg::A_DFIN: n_state = pse_pkg::A_DONE;
            pse_pkg::A_DONE: n_state = pse_pkg::A_IDLE;
            default:         n_state = pse_pkg::A_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.value = r_val;
        o_rsp.sat   = r_sat;
        unique case (r_state)
            pse_pkg::A_DONE: o_rsp.done = 1'b1;
            default:         o_rsp.done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pse_pkg::A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pse_pkg::A_IDLE: begin
                if (i_cmd.start) begin
                    r_prod <= $signed(i_a) * $signed(i_b);
                    r_val  <= w_sum[QW] ? (w_sum_sat ? pse_pkg::Q_MIN : w_sum[QW-1:0])
                                        : (w_sum_sat ? pse_pkg::Q_MAX : w_sum[QW-1:0]);
                    r_sat  <= w_sum_sat;
                    r_rem  <= {{(QW-FW){1'b0}}, w_num[N_W-1:QW]};
                    r_quo  <= w_num[QW-1:0];
                    r_div  <= w_b_mag;
                    r_neg  <= i_a[QW-1] ^ i_b[QW-1];
                    r_big  <= w_big;
                    r_step <= '0;
                end
            end
            pse_pkg::A_MULR: begin
                r_sat <= w_mul_sat;
                r_val <= w_mul_sat ? (w_shr[P_W-1] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX)
                                   : w_shr[QW-1:0];
            end
            pse_pkg::A_DIV: begin
                r_rem  <= w_ge ? w_diff[QW-1:0] : w_trial[QW-1:0];
                r_quo  <= {r_quo[QW-2:0], w_ge};
                r_step <= r_step + 1'b1;
            end
            pse_pkg::A_DFIN: begin
                r_val <= w_dfin_val;
                r_sat <= w_dfin_sat;
            end
            default: begin
                r_val <= r_val;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator: token decode, stack control, result register.
// Push, finish and invalid tokens do not raise busy; it stays low after them.
// Add, subtract, multiply and divide keep busy high; the divider retires one
// quotient bit per cycle, after the operand read and before sign fixup and writeback.
// A finish result is shown on o_strobe the cycle after its transaction; the receiver cannot stall.
// Synchronous reset clears stack count, error and control; the stack memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_evaluator (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire pse_pkg::t_in_item    i_item,
    output logic                      o_strobe,
    output pse_pkg::t_out_item        o_result
);

    localparam int QW = pse_pkg::Q_W;
    localparam int CW = pse_pkg::CNT_W;
    localparam int AW = pse_pkg::ADDR_W;

    pse_pkg::t_ctl_state r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    pse_pkg::t_status    r_err, n_err;
    logic [QW-1:0]       r_tos, n_tos;
    pse_pkg::t_kind      r_op, n_op;
    logic                r_strobe, n_strobe;
    pse_pkg::t_out_item  r_result, n_result;

    logic                w_accept;
    logic                w_issue;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic [QW-1:0]       w_rdata;
    pse_pkg::t_alu_cmd   w_cmd;
    pse_pkg::t_alu_rsp   w_rsp;

    assign w_accept = start && !busy;
    assign w_waddr  = AW'(r_count - 1'b1);
    assign w_raddr  = AW'(r_count - CW'(2));

    pse_ram #(
        .WIDTH (QW),
        .DEPTH (pse_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_tos),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pse_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_a     (w_rdata),
        .i_b     (r_tos),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_count  = r_count;
        n_err    = r_err;
        n_tos    = r_tos;
        n_op     = r_op;
        n_strobe = 1'b0;
        n_result = r_result;
        w_we     = 1'b0;
        w_issue  = 1'b0;
        if (w_accept) begin
            if (i_item.kind == pse_pkg::K_FINISH) begin
                n_strobe              = 1'b1;
                n_result.result_value = '0;
                n_result.status       = r_err;
                if (r_err == pse_pkg::ST_OK) begin
                    if (r_count == CW'(1)) begin
                        n_result.result_value = r_tos;
                    end else begin
                        n_result.status = pse_pkg::ST_COUNT;
                    end
                end
                n_count = '0;
                n_err   = pse_pkg::ST_OK;
            end else if (r_err == pse_pkg::ST_OK) begin
                case (i_item.kind) inside
                    pse_pkg::K_OPERAND: begin
                        if (r_count == CW'(pse_pkg::STACK_DEPTH)) begin
                            n_err = pse_pkg::ST_OVERFLOW;
                        end else begin
                            w_we    = (r_count != '0);
                            n_tos   = i_item.operand_value;
                            n_count = r_count + 1'b1;
                        end
                    end
                    pse_pkg::K_ADD, pse_pkg::K_SUB, pse_pkg::K_MUL, pse_pkg::K_DIV: begin
                        if (r_count < CW'(2)) begin
                            n_err = pse_pkg::ST_FEW;
                        end else if ((i_item.kind == pse_pkg::K_DIV) && (r_tos == '0)) begin
                            n_err = pse_pkg::ST_DIVZERO;
                        end else begin
                            w_issue = 1'b1;
                            n_op    = i_item.kind;
                        end
                    end
                    default: begin
                        n_err = pse_pkg::ST_INVALID;
                    end
                endcase
            end
        end
        if ((r_state == pse_pkg::S_WAIT) && w_rsp.done) begin
            n_tos   = w_rsp.value;
            n_count = r_count - 1'b1;
            if (w_rsp.sat) begin
                n_err = pse_pkg::ST_SAT;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pse_pkg::S_IDLE: begin
                if (w_issue) begin
                    n_state = pse_pkg::S_READ;
                end
            end
            pse_pkg::S_READ: n_state = pse_pkg::S_WAIT;
            pse_pkg::S_WAIT: begin
                if (w_rsp.done) begin
                    n_state = pse_pkg::S_IDLE;
                end
            end
            default: n_state = pse_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_cmd.op = r_op;
        unique case (r_state)
            pse_pkg::S_IDLE: begin
                busy        = 1'b0;
                w_cmd.start = 1'b0;
            end
            pse_pkg::S_READ: begin
                busy        = 1'b1;
                w_cmd.start = 1'b1;
            end
            default: begin
                busy        = 1'b1;
                w_cmd.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pse_pkg::S_IDLE;
            r_count  <= '0;
            r_err    <= pse_pkg::ST_OK;
            r_strobe <= 1'b0;
            r_op     <= pse_pkg::K_ADD;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_err    <= n_err;
            r_strobe <= n_strobe;
            r_op     <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos    <= n_tos;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_finish_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.kind == pse_pkg::K_FINISH)) |=> r_strobe)
        else $error("finish transaction without result strobe");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(w_accept && (i_item.kind == pse_pkg::K_FINISH)))
        else $error("result strobe without finish transaction");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == pse_pkg::S_WAIT))
        else $error("arithmetic result outside wait state");

    a_pop_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == pse_pkg::S_WAIT) && w_rsp.done) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("stack count not dropped after operator");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue |-> (r_count >= CW'(2))) and (r_count <= CW'(pse_pkg::STACK_DEPTH)))
        else $error("stack count out of range");

endmodule

`default_nettype wire

// ===== bench/postfix_stack_evaluator_tb.sv =====
// Self-checking testbench for the postfix stack evaluator: directed table, then random expressions.
`timescale 1ns / 1ps

module postfix_stack_evaluator_tb;

    import pse_pkg::*;

    localparam t_kind   K_RESERVED  = t_kind'(3'd7);
    localparam int      IDLE_LIMIT  = 2000;
    localparam int      TAIL_CYCLES = 40;
    localparam int      N_RANDOM    = 600;
    localparam int      DRAIN_EVERY = 150;
    localparam int      N_DIR       = 36;
    localparam longint  SAT_HI      = 64'sd2147483647;
    localparam longint  SAT_LO      = -64'sd2147483648;

    typedef struct packed {
        t_kind          kind;
        logic [Q_W-1:0] value;
        logic [7:0]     reps;
        logic           typed;
        logic [Q_W-1:0] exp_value;
        t_status        exp_status;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   i_item;
    logic       o_strobe;
    t_out_item  o_result;

    logic       typed_check;
    t_out_item  typed_result;

    t_out_item              pending_results[$];
    logic signed [Q_W-1:0]  shadow_stack [STACK_DEPTH];
    int                     shadow_count;
    t_status                shadow_error;

    int n_errors;
    int n_accepted;
    int n_sent;
    int idle_cycles;
    int burst_left;
    bit quiet_run;

    t_dir_row dir_rows [N_DIR] = '{
        '{K_FINISH,  32'h0,         8'd1,   1'b1, 32'h0, ST_COUNT},
        '{K_OPERAND, Q_MIN,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b1, Q_MIN, ST_OK},
        '{K_OPERAND, Q_MAX,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_OPERAND, 32'h1,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_ADD,     32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b1, 32'h0, ST_SAT},
        '{K_OPERAND, 32'h0001_8000, 8'd1,   1'b0, 32'h0, ST_OK},
        '{K_OPERAND, 32'h0002_4000, 8'd1,   1'b0, 32'h0, ST_OK},
        '{K_MUL,     32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_OPERAND, 32'hFFFD_0000, 8'd1,   1'b0, 32'h0, ST_OK},
        '{K_DIV,     32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_OPERAND, 32'h1,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_OPERAND, 32'h0000_8000, 8'd1,   1'b0, 32'h0, ST_OK},
        '{K_MUL,     32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_OPERAND, 32'hFFFF_FFFF, 8'd1,   1'b0, 32'h0, ST_OK},
        '{K_OPERAND, 32'h0000_8000, 8'd1,   1'b0, 32'h0, ST_OK},
        '{K_MUL,     32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_SUB,     32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_ADD,     32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b1, 32'h0, ST_FEW},
        '{K_OPERAND, 32'h0001_0000, 8'd1,   1'b0, 32'h0, ST_OK},
        '{K_OPERAND, 32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_DIV,     32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b1, 32'h0, ST_DIVZERO},
        '{K_INVALID, 32'h0,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b1, 32'h0, ST_INVALID},
        '{K_RESERVED, 32'hFFFF_FFFF, 8'd1,  1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b1, 32'h0, ST_INVALID},
        '{K_OPERAND, 32'h0007_0000, 8'd129, 1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b1, 32'h0, ST_OVERFLOW},
        '{K_OPERAND, 32'h5,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_OPERAND, 32'h7,         8'd1,   1'b0, 32'h0, ST_OK},
        '{K_FINISH,  32'h0,         8'd1,   1'b1, 32'h0, ST_COUNT}
    };

    postfix_stack_evaluator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        n_errors++;
    endtask

    function automatic bit evaluate_token(input t_in_item tok, output t_out_item res);
        longint lhs;
        longint rhs;
        longint raw;
        res = '0;
        if (tok.kind == K_FINISH) begin
            res.status = shadow_error;
            if (shadow_error == ST_OK) begin
                if (shadow_count == 1) begin
                    res.result_value = shadow_stack[0];
                end else begin
                    res.status = ST_COUNT;
                end
            end
            shadow_count = 0;
            shadow_error = ST_OK;
            return 1'b1;
        end
        if (shadow_error != ST_OK) return 1'b0;
        case (tok.kind)
            K_OPERAND: begin
                if (shadow_count >= STACK_DEPTH) begin
                    shadow_error = ST_OVERFLOW;
                end else begin
                    shadow_stack[shadow_count] = tok.operand_value;
                    shadow_count++;
                end
            end
            K_ADD, K_SUB, K_MUL, K_DIV: begin
                if (shadow_count < 2) begin
                    shadow_error = ST_FEW;
                    return 1'b0;
                end
                rhs = shadow_stack[shadow_count-1];
                lhs = shadow_stack[shadow_count-2];
                case (tok.kind)
                    K_ADD: raw = lhs + rhs;
                    K_SUB: raw = lhs - rhs;
                    K_MUL: raw = (lhs * rhs + 64'sd32768) >>> 16;
                    default: begin
                        if (rhs == 0) begin
                            shadow_error = ST_DIVZERO;
                            return 1'b0;
                        end
                        raw = (lhs * 64'sd65536) / rhs;
                    end
                endcase
                shadow_count--;
                if (raw > SAT_HI) begin
                    shadow_stack[shadow_count-1] = Q_MAX;
                    shadow_error = ST_SAT;
                end else if (raw < SAT_LO) begin
                    shadow_stack[shadow_count-1] = Q_MIN;
                    shadow_error = ST_SAT;
                end else begin
                    shadow_stack[shadow_count-1] = raw[Q_W-1:0];
                end
            end
            default: shadow_error = ST_INVALID;
        endcase
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item predicted;
        t_out_item want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                              o_result.result_value, o_result.status));
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.result_value !== want.result_value)
                        report_mismatch($sformatf("result_value %h, expected %h",
                                                  o_result.result_value, want.result_value));
                    if (o_result.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_result.status, want.status));
                end
            end
            if (start && !busy) begin
                if (evaluate_token(i_item, predicted))
                    pending_results.push_back(typed_check ? typed_result : predicted);
                n_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("postfix_stack_evaluator test failed");
                $finish;
            end
        end
    end

    task automatic send_token(input t_kind k, input logic [Q_W-1:0] v, input logic chk,
                              input t_out_item want);
        int seen;
        int gap;
        start = 1'b1;
        i_item.kind = k;
        i_item.operand_value = v;
        typed_check = chk;
        typed_result = want;
        seen = n_accepted;
        do @(negedge i_clk); while (n_accepted == seen);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if (!quiet_run) begin
                gap = $urandom_range(1, 6);
                start = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_results_drained();
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [Q_W-1:0] random_operand();
        logic [Q_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                v = $urandom_range(0, 32'h0004_0000);
                if ($urandom_range(0, 1)) v = -v;
            end
            5, 6, 7: v = $urandom;
            8: begin
                case ($urandom_range(0, 5))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = 32'h0001_0000;
                    3: v = 32'hFFFF_0000;
                    4: v = 32'h1;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    task automatic send_expression();
        bit   deep;
        bit   noisy;
        int   pushes_left;
        int   depth;
        t_kind k;
        deep = ($urandom_range(0, 79) == 0);
        noisy = ($urandom_range(0, 4) == 0);
        quiet_run = ($urandom_range(0, 3) == 0);
        pushes_left = deep ? $urandom_range(127, 130) : $urandom_range(1, 6);
        depth = 0;
        while (pushes_left > 0 || depth > 1) begin
            if (pushes_left > 0 && (depth < 2 || deep || $urandom_range(0, 1))) begin
                k = K_OPERAND;
                pushes_left--;
                depth++;
            end else begin
                k = t_kind'($urandom_range(K_ADD, K_DIV));
                depth--;
            end
            if (noisy && $urandom_range(0, 7) == 0) k = t_kind'($urandom_range(0, 7));
            send_token(k, random_operand(), 1'b0, '0);
        end
        send_token(K_FINISH, random_operand(), 1'b0, '0);
    endtask

    initial begin
        t_out_item want;
        int        last_drain;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        typed_check = 1'b0;
        typed_result = '0;
        shadow_count = 0;
        shadow_error = ST_OK;
        n_errors = 0;
        n_accepted = 0;
        n_sent = 0;
        idle_cycles = 0;
        burst_left = 1;
        quiet_run = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            want.result_value = dir_rows[r].exp_value;
            want.status = dir_rows[r].exp_status;
            repeat (dir_rows[r].reps)
                send_token(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].typed, want);
        end
        wait_results_drained();

        last_drain = n_sent;
        while (n_sent < N_DIR + N_RANDOM) begin
            send_expression();
            if (n_sent - last_drain >= DRAIN_EVERY) begin
                wait_results_drained();
                last_drain = n_sent;
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (n_errors == 0) begin
            $display("postfix_stack_evaluator test passed");
        end else begin
            $display("postfix_stack_evaluator test failed");
        end
        $finish;
    end

endmodule
